// File: design/phd_pkg.sv
// Shared constants, codes, result type and group tables of the photo header parser.
`default_nettype none

package phd_pkg;

    // Parameter defaults
    localparam int MAX_VALUE_BYTES_DEF = 4;
    localparam int LENGTH_BITS_DEF     = 15;

    // Parser phase codes
    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_TYPE   = 3'd2;
    localparam logic [2:0] PH_ROW    = 3'd3;
    localparam logic [2:0] PH_COL    = 3'd4;
    localparam logic [2:0] PH_TAG    = 3'd5;
    localparam logic [2:0] PH_LEN    = 3'd6;
    localparam logic [2:0] PH_DATA   = 3'd7;

    // Value kinds
    localparam logic [1:0] KIND_BOOL = 2'd0;
    localparam logic [1:0] KIND_REAL = 2'd1;
    localparam logic [1:0] KIND_INT  = 2'd2;

    // Event codes
    localparam logic [2:0] EV_VALUE = 3'd0;
    localparam logic [2:0] EV_RESET = 3'd1;
    localparam logic [2:0] EV_DONE  = 3'd2;
    localparam logic [2:0] EV_DATA  = 3'd3;
    localparam logic [2:0] EV_ERROR = 3'd4;
    localparam logic [2:0] EV_NONE  = 3'd7;

    // Group codes
    localparam logic [2:0] GRP_NONE = 3'd7;

    // Byte values of the header syntax
    localparam logic [7:0] PREFIX_0   = 8'h23;
    localparam logic [7:0] PREFIX_1   = 8'h40;
    localparam logic [7:0] PREFIX_2   = 8'h7F;
    localparam logic [1:0] PREFIX_LEN = 2'd3;
    localparam logic [7:0] TAG_BOOL   = 8'h45;
    localparam logic [7:0] TAG_REAL   = 8'h42;
    localparam logic [7:0] TAG_INT    = 8'h40;
    localparam logic [7:0] TYPE_PHOTO = 8'h50;
    localparam logic [7:0] TYPE_START = 8'h52;
    localparam logic [7:0] ROW_BASE   = 8'h20;
    localparam logic [7:0] COL_BASE   = 8'h30;
    localparam logic [7:0] INT_SIGN   = 8'h40;
    localparam logic [7:0] INT_MAG    = 8'h3F;
    localparam logic [4:0] TABLE_MAX  = 5'd4;
    localparam logic [14:0] DLEN_MAX  = 15'h7FFF;

    // One result transaction
    typedef struct packed {
        logic               valid;
        logic [2:0]         event_res;
        logic [3:0]         field_id;
        logic signed [31:0] value;
        logic [14:0]        data_length;
    } result_t;

    function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = PREFIX_0;
            2'd1:    r = PREFIX_1;
            default: r = PREFIX_2;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kind_tag(input logic [1:0] kind);
        logic [7:0] r;
        unique case (kind)
            KIND_BOOL: r = TAG_BOOL;
            KIND_REAL: r = TAG_REAL;
            KIND_INT:  r = TAG_INT;
            default:   r = 8'h00;
        endcase
        return r;
    endfunction

    // Row/column pair to group index
    function automatic logic [2:0] group_of(input logic [2:0] row, input logic [2:0] col);
        logic [2:0] r;
        unique case ({row, col})
            {3'd0, 3'd0}: r = 3'd0;
            {3'd1, 3'd2}: r = 3'd1;
            {3'd1, 3'd3}: r = 3'd2;
            {3'd1, 3'd4}: r = 3'd3;
            {3'd2, 3'd1}: r = 3'd4;
            default:      r = GRP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] grp_count(input logic [2:0] g);
        logic [2:0] r;
        unique case (g)
            3'd0:    r = 3'd1;
            3'd3:    r = 3'd4;
            default: r = 3'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] grp_kind(input logic [2:0] g, input logic [1:0] item);
        logic [1:0] r;
        unique case (g)
            3'd0:    r = KIND_BOOL;
            3'd1:    r = (item < 2'd2) ? KIND_REAL : KIND_BOOL;
            3'd2:    r = (item < 2'd2) ? KIND_REAL : KIND_BOOL;
            3'd3:    r = (item < 2'd2) ? KIND_INT : KIND_REAL;
            3'd4:    r = (item < 2'd2) ? KIND_INT : KIND_BOOL;
            default: r = KIND_BOOL;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] grp_field(input logic [2:0] g, input logic [1:0] item);
        logic [3:0] r;
        unique case (g)
            3'd1:    r = (item < 2'd2) ? {3'd0, item[0]} : 4'd0;
            3'd2:    r = (item < 2'd2) ? {3'd1, item[0]} : 4'd0;
            3'd3:    r = 4'd4 + {2'd0, item};
            3'd4:    r = (item < 2'd2) ? {3'd4, item[0]} : 4'd0;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/photo_header_parser_unit.sv
// Top level of the videotex photo header parser: input register, parser, result register.
//
// Photo header parser. One byte is accepted per transaction on the byte channel and at
// most one result transaction comes out for it. The block sustains one byte per clock
// while the result side takes its results: a byte is held in the input register, and
// when it advances the parser updates its state and loads the result register from it.
// While the result register holds an untaken result, bytes that produce no result still
// pass; the input side stalls only when the input register is full and cannot advance.
// Reals come out in Q5.26, integers saturated to 32 bits. No clearing pass after reset.
`default_nettype none

module photo_header_parser_unit #(
    parameter int MAX_VALUE_BYTES = phd_pkg::MAX_VALUE_BYTES_DEF,
    parameter int LENGTH_BITS     = phd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire logic [7:0]         in_byte,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [2:0]              event_res,
    output logic [3:0]              field_id,
    output logic signed [31:0]      value,
    output logic [14:0]             data_length
);

    logic             byte_vld_reg, byte_vld_next;
    logic [7:0]       byte_reg;
    logic             res_vld_reg, res_vld_next;
    phd_pkg::result_t res_reg;
    phd_pkg::result_t step_res;
    logic             accept;
    logic             advance;

    // Pipeline control
    assign advance    = byte_vld_reg && (!step_res.valid || !res_vld_reg || !result_stall);
    assign byte_stall = byte_vld_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        byte_vld_next = byte_vld_reg;
        if (accept)
        begin
            byte_vld_next = 1'b1;
        end
        else if (advance)
        begin
            byte_vld_next = 1'b0;
        end

        res_vld_next = res_vld_reg;
        if (res_vld_reg && !result_stall)
        begin
            res_vld_next = 1'b0;
        end
        if (advance && step_res.valid)
        begin
            res_vld_next = 1'b1;
        end
    end

    phd_parser #(
        .MAX_VALUE_BYTES(MAX_VALUE_BYTES),
        .LENGTH_BITS    (LENGTH_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step_en(advance),
        .byte_in(byte_reg),
        .result (step_res)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            byte_vld_reg <= byte_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
        end
        if (advance && step_res.valid)
        begin
            res_reg <= step_res;
        end
    end

    assign result_valid = res_vld_reg;
    assign event_res    = res_reg.event_res;
    assign field_id     = res_reg.field_id;
    assign value        = res_reg.value;
    assign data_length  = res_reg.data_length;

endmodule

`default_nettype wire

// File: design/phd_value_conv.sv
// Conversion of an assembled 7-bit-group value to Q5.26 real or saturated int32.
`default_nettype none

module phd_value_conv #(
    parameter int MAX_VALUE_BYTES = phd_pkg::MAX_VALUE_BYTES_DEF
) (
    input  wire logic [7*MAX_VALUE_BYTES-1:0] acc,
    input  wire logic [3:0]                   len,
    input  wire logic                         neg,
    input  wire logic                         is_real,
    output logic signed [31:0]                value
);

    localparam int ACC_W = 7 * MAX_VALUE_BYTES;
    localparam int W     = (ACC_W > 32) ? ACC_W : 32;

    logic [W-1:0]        acc_w;
    logic [6:0]          nbits;
    logic [6:0]          lsh;
    logic [6:0]          rsh;
    logic                sign;
    logic [W-1:0]        sext;
    logic signed [W-1:0] sext_s;
    logic [W-1:0]        left_v;
    logic signed [W-1:0] right_v;
    logic                over;
    logic [31:0]         real_v;
    logic [31:0]         int_v;

    assign acc_w = W'(acc);
    assign nbits = 7'(len) * 7'd7;
    assign lsh   = 7'd28 - nbits;
    assign rsh   = nbits - 7'd28;

    // Sign extension from bit nbits-1
    assign sign    = |(acc_w & (W'(1) << (nbits - 7'd1)));
    assign sext    = sign ? (acc_w | ({W{1'b1}} << nbits)) : acc_w;
    assign sext_s  = $signed(sext);
    assign left_v  = sext << lsh;
    assign right_v = sext_s >>> rsh;

    // Up to 26 fraction bits shift left, otherwise floor shift right
    assign real_v = (nbits <= 7'd28) ? left_v[31:0] : right_v[31:0];

    // Sign-magnitude integer with saturation
    assign over = |acc_w[W-1:31];
    always_comb
    begin
        if (neg)
        begin
            int_v = over ? 32'h8000_0000 : (32'd0 - acc_w[31:0]);
        end
        else
        begin
            int_v = over ? 32'h7FFF_FFFF : acc_w[31:0];
        end
    end

    assign value = is_real ? $signed(real_v) : $signed(int_v);

endmodule

`default_nettype wire

// File: design/phd_parser.sv
// Parser state registers and the combinational next-state and result logic.
`default_nettype none

module phd_parser #(
    parameter int MAX_VALUE_BYTES = phd_pkg::MAX_VALUE_BYTES_DEF,
    parameter int LENGTH_BITS     = phd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire logic [7:0]  byte_in,
    output phd_pkg::result_t result
);

    localparam int ACC_W = 7 * MAX_VALUE_BYTES;

    logic [2:0]             phase_reg, phase_next;
    logic [1:0]             pidx_reg, pidx_next;
    logic [LENGTH_BITS-1:0] hbl_reg, hbl_next;
    logic [2:0]             row_reg, row_next;
    logic [2:0]             item_reg, item_next;
    logic [1:0]             kind_reg, kind_next;
    logic [3:0]             vbl_reg, vbl_next;
    logic [3:0]             vlen_reg, vlen_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic                   neg_reg, neg_next;

    logic [LENGTH_BITS-1:0] hbl_dec;
    logic [2:0]             grp;
    logic [2:0]             row_code;
    logic [2:0]             col_code;
    logic [2:0]             col_grp;
    logic                   sign_first;
    logic                   data_neg;
    logic [6:0]             data_bits;
    logic [ACC_W-1:0]       data_acc;
    logic [3:0]             data_vbl;
    logic signed [31:0]     conv_value;
    logic [2:0]             item_inc;
    logic [2:0]             ev;
    logic                   restart;
    logic                   end_grp;
    logic                   item_done;

    // Decode helpers
    assign hbl_dec  = hbl_reg - LENGTH_BITS'(1);
    assign grp      = (row_reg <= 3'(phd_pkg::TABLE_MAX)) ? row_reg : 3'd0;
    assign row_code = (byte_in >= phd_pkg::ROW_BASE &&
                       byte_in <= phd_pkg::ROW_BASE + 8'(phd_pkg::TABLE_MAX))
                      ? 3'(byte_in - phd_pkg::ROW_BASE) : 3'd7;
    assign col_code = (byte_in >= phd_pkg::COL_BASE &&
                       byte_in <= phd_pkg::COL_BASE + 8'(phd_pkg::TABLE_MAX))
                      ? 3'(byte_in - phd_pkg::COL_BASE) : 3'd7;
    assign col_grp  = phd_pkg::group_of(row_reg, col_code);
    assign item_inc = item_reg + 3'd1;

    // Value data byte: sign capture and accumulation
    assign sign_first = (kind_reg == phd_pkg::KIND_INT) && (vbl_reg == vlen_reg) &&
                        ((byte_in & phd_pkg::INT_SIGN) != 8'h00);
    assign data_neg   = neg_reg | sign_first;
    assign data_bits  = sign_first ? (byte_in[6:0] & phd_pkg::INT_MAG[6:0]) : byte_in[6:0];
    assign data_acc   = (acc_reg << 7) | ACC_W'(data_bits);
    assign data_vbl   = (vbl_reg != 4'd0) ? vbl_reg - 4'd1 : 4'd0;

    phd_value_conv #(
        .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
    ) u_conv (
        .acc    (data_acc),
        .len    (vlen_reg),
        .neg    (data_neg),
        .is_real(kind_reg == phd_pkg::KIND_REAL),
        .value  (conv_value)
    );

    // Next state and result
    always_comb
    begin
        phase_next = phase_reg;
        pidx_next  = pidx_reg;
        hbl_next   = hbl_reg;
        row_next   = row_reg;
        item_next  = item_reg;
        kind_next  = kind_reg;
        vbl_next   = vbl_reg;
        vlen_next  = vlen_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        ev         = phd_pkg::EV_NONE;
        restart    = 1'b0;
        end_grp    = 1'b0;
        item_done  = 1'b0;
        result     = '0;

        unique case (phase_reg)
            phd_pkg::PH_PREFIX:
            begin
                if (pidx_reg < phd_pkg::PREFIX_LEN &&
                    byte_in == phd_pkg::prefix_byte(pidx_reg))
                begin
                    if (pidx_reg == phd_pkg::PREFIX_LEN - 2'd1)
                    begin
                        pidx_next  = 2'd0;
                        hbl_next   = '0;
                        phase_next = phd_pkg::PH_LENGTH;
                    end
                    else
                    begin
                        pidx_next = pidx_reg + 2'd1;
                    end
                end
                else
                begin
                    pidx_next = (byte_in == phd_pkg::PREFIX_0) ? 2'd1 : 2'd0;
                end
            end
            phd_pkg::PH_LENGTH:
            begin
                hbl_next = LENGTH_BITS'({hbl_reg, byte_in[4:0]});
                if (!byte_in[5])
                begin
                    phase_next = phd_pkg::PH_TYPE;
                end
            end
            default:
            begin
                if (hbl_reg == '0)
                begin
                    restart = 1'b1;
                    ev      = phd_pkg::EV_ERROR;
                end
                else
                begin
                    hbl_next = hbl_dec;
                    unique case (phase_reg)
                        phd_pkg::PH_TYPE:
                        begin
                            if (byte_in[7:1] == phd_pkg::TYPE_PHOTO[7:1])
                            begin
                                phase_next = phd_pkg::PH_ROW;
                            end
                            else if (byte_in[7:1] == phd_pkg::TYPE_START[7:1])
                            begin
                                restart = 1'b1;
                                if (hbl_dec == '0)
                                begin
                                    ev = phd_pkg::EV_DONE;
                                end
                                else
                                begin
                                    ev = phd_pkg::EV_DATA;
                                    result.data_length =
                                        (32'(hbl_dec) > 32'(phd_pkg::DLEN_MAX))
                                        ? phd_pkg::DLEN_MAX : 15'(hbl_dec);
                                end
                            end
                            else
                            begin
                                restart = 1'b1;
                                ev      = phd_pkg::EV_ERROR;
                            end
                        end
                        phd_pkg::PH_ROW:
                        begin
                            row_next   = row_code;
                            phase_next = phd_pkg::PH_COL;
                        end
                        phd_pkg::PH_COL:
                        begin
                            if (col_grp == phd_pkg::GRP_NONE)
                            begin
                                row_next = 3'd0;
                                end_grp  = 1'b1;
                            end
                            else
                            begin
                                row_next   = col_grp;
                                item_next  = 3'd0;
                                kind_next  = phd_pkg::grp_kind(col_grp, 2'd0);
                                phase_next = phd_pkg::PH_TAG;
                            end
                        end
                        phd_pkg::PH_TAG:
                        begin
                            if (kind_reg > phd_pkg::KIND_INT ||
                                byte_in != phd_pkg::kind_tag(kind_reg))
                            begin
                                restart = 1'b1;
                                ev      = phd_pkg::EV_ERROR;
                            end
                            else
                            begin
                                phase_next = phd_pkg::PH_LEN;
                            end
                        end
                        phd_pkg::PH_LEN:
                        begin
                            if ((kind_reg == phd_pkg::KIND_BOOL) ? (byte_in != 8'd1) :
                                (byte_in == 8'd0 || byte_in > 8'(MAX_VALUE_BYTES)))
                            begin
                                restart = 1'b1;
                                ev      = phd_pkg::EV_ERROR;
                            end
                            else
                            begin
                                vlen_next  = byte_in[3:0];
                                vbl_next   = byte_in[3:0];
                                acc_next   = '0;
                                neg_next   = 1'b0;
                                phase_next = phd_pkg::PH_DATA;
                            end
                        end
                        default:
                        begin
                            // Data byte of a value
                            if (kind_reg == phd_pkg::KIND_BOOL)
                            begin
                                if (byte_in > 8'd1)
                                begin
                                    restart = 1'b1;
                                    ev      = phd_pkg::EV_ERROR;
                                end
                                else
                                begin
                                    if (byte_in == 8'd1)
                                    begin
                                        ev = phd_pkg::EV_RESET;
                                    end
                                    vbl_next  = 4'd0;
                                    item_done = 1'b1;
                                end
                            end
                            else
                            begin
                                neg_next = data_neg;
                                acc_next = data_acc;
                                vbl_next = data_vbl;
                                if (data_vbl == 4'd0)
                                begin
                                    ev              = phd_pkg::EV_VALUE;
                                    result.field_id = phd_pkg::grp_field(grp, item_reg[1:0]);
                                    result.value    = conv_value;
                                    item_done       = 1'b1;
                                end
                            end
                            if (item_done)
                            begin
                                item_next = item_inc;
                                if (item_inc >= phd_pkg::grp_count(grp))
                                begin
                                    end_grp = 1'b1;
                                end
                                else
                                begin
                                    kind_next  = phd_pkg::grp_kind(grp, item_inc[1:0]);
                                    phase_next = phd_pkg::PH_TAG;
                                end
                            end
                        end
                    endcase
                end
            end
        endcase

        // Group close: header end returns to the prefix search, otherwise a row byte follows
        if (end_grp)
        begin
            if (hbl_dec == '0)
            begin
                restart = 1'b1;
                if (ev == phd_pkg::EV_NONE)
                begin
                    ev = phd_pkg::EV_DONE;
                end
            end
            else
            begin
                phase_next = phd_pkg::PH_ROW;
            end
        end

        if (restart)
        begin
            phase_next = phd_pkg::PH_PREFIX;
            pidx_next  = 2'd0;
            hbl_next   = '0;
            row_next   = 3'd0;
            item_next  = 3'd0;
            kind_next  = phd_pkg::KIND_BOOL;
            vbl_next   = 4'd0;
            vlen_next  = 4'd0;
            acc_next   = '0;
            neg_next   = 1'b0;
        end

        result.valid     = (ev != phd_pkg::EV_NONE);
        result.event_res = result.valid ? ev : 3'd0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= phd_pkg::PH_PREFIX;
            pidx_reg  <= 2'd0;
            hbl_reg   <= '0;
            row_reg   <= 3'd0;
            item_reg  <= 3'd0;
            kind_reg  <= phd_pkg::KIND_BOOL;
            vbl_reg   <= 4'd0;
            vlen_reg  <= 4'd0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            pidx_reg  <= pidx_next;
            hbl_reg   <= hbl_next;
            row_reg   <= row_next;
            item_reg  <= item_next;
            kind_reg  <= kind_next;
            vbl_reg   <= vbl_next;
            vlen_reg  <= vlen_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
        end
    end

endmodule

`default_nettype wire
